/* hdl/cdad_pkg.sv */
// Package with the types, constants and calendar functions of the date adder.
package cdad_pkg;

    localparam int ADD_WIDTH = 16;
    localparam int DAYS_W    = 16;
    localparam int XW        = (ADD_WIDTH > 9) ? ADD_WIDTH : 9;
    localparam int AW        = (XW > 14) ? XW : 14;

    localparam logic [XW-1:0] X_MASK = XW'((64'd1 << ADD_WIDTH) - 64'd1);

    localparam logic [13:0] YEAR_MIN  = 14'd1500;
    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [13:0] CYCLE_LEN = 14'd400;
    localparam logic [8:0]  CYCLE_TOP = 9'd399;
    localparam logic [3:0]  MONTH_DEC = 4'd12;
    localparam logic [4:0]  DAY_DEC31 = 5'd31;

    typedef struct packed {
        logic [4:0]        start_day;
        logic [3:0]        start_month;
        logic [13:0]       start_year;
        logic [DAYS_W-1:0] days_to_add;
    } t_req;

    typedef struct packed {
        logic [4:0]  new_day;
        logic [3:0]  new_month;
        logic [13:0] new_year;
        logic        date_invalid;
        logic        year_overflow;
    } t_rsp;

    typedef enum logic [0:0] {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op       op;
        logic [AW-1:0] a;
        logic [AW-1:0] b;
    } t_alu_in;

    typedef struct packed {
        logic [AW-1:0] res;
        logic          borrow;
        logic          zero;
    } t_alu_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_CHECK,
        S_DOY,
        S_REM,
        S_FIRST,
        S_ADDX,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    // Leap rule from the year taken modulo 400.
    function automatic logic leap_of(input logic [8:0] r400);
        logic century;
        century = (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
        return (r400[1:0] == 2'b00) && !century;
    endfunction

    function automatic logic [8:0] year_days(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

/* hdl/cdad_if.sv */
// Valid/ready channels that carry date requests and results.
interface cdad_req_if;
    import cdad_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cdad_rsp_if;
    import cdad_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/cdad_alu.sv */
// Shared add and subtract unit with borrow and zero flags.
module cdad_alu (
    input  cdad_pkg::t_alu_in  i_op,
    output cdad_pkg::t_alu_out o_res
);
    import cdad_pkg::*;

    logic [AW:0] sum;

    always_comb begin
        if (i_op.op == ALU_SUB) begin
            sum = {1'b0, i_op.a} - {1'b0, i_op.b};
        end else begin
            sum = {1'b0, i_op.a} + {1'b0, i_op.b};
        end
        o_res.res    = sum[AW-1:0];
        o_res.borrow = (i_op.op == ALU_SUB) && sum[AW];
        o_res.zero   = (sum[AW-1:0] == '0);
    end
endmodule

/* hdl/calendar_date_add_days.sv */
// Top level of the date adder: request sequencer, working registers and result register.
// The sequencer reduces the year modulo 400 and checks the date; an invalid date goes
// straight to the result. Otherwise it sums the day of the year month by month, takes
// the days left in the year, and either adds the day count within the year or steps
// year by year (saturating on overflow); the day offset is then split into months.
// It then returns to idle. The modulo, day and month arithmetic goes through the one
// shared add/subtract unit. A new request is taken only when the sequencer is idle; a
// finished result waits in its own register.
module calendar_date_add_days (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cdad_req_if.sink       i_req,
    cdad_rsp_if.source     o_rsp
);
    import cdad_pkg::*;

    t_state        r_state, n_state;
    logic [4:0]    r_d;
    logic [3:0]    r_m, n_m;
    logic [13:0]   r_y, n_y;
    logic [13:0]   r_r400, n_r400;
    logic [XW-1:0] r_x, n_x;
    logic [8:0]    r_doy, n_doy;
    logic [8:0]    r_off, n_off;
    logic [3:0]    r_i, n_i;
    logic          r_bad, n_bad;
    logic          r_ovf, n_ovf;
    logic          r_ov, n_ov;
    t_rsp          r_out, n_out;
    t_alu_in       alu_in;
    t_alu_out      alu_out;
    logic          leap;
    logic [8:0]    r400_inc;
    logic          date_ok;

    cdad_alu u_alu (
        .i_op  (alu_in),
        .o_res (alu_out)
    );

    assign leap     = leap_of(r_r400[8:0]);
    assign r400_inc = (r_r400[8:0] == CYCLE_TOP) ? 9'd0 : r_r400[8:0] + 9'd1;
    assign date_ok  = (r_y >= YEAR_MIN) && (r_y <= YEAR_MAX) && (r_m >= 4'd1) &&
                      (r_m <= MONTH_DEC) && (r_d >= 5'd1) && (r_d <= month_days(r_m, leap));

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_m    <= n_m;
        r_y    <= n_y;
        r_r400 <= n_r400;
        r_x    <= n_x;
        r_doy  <= n_doy;
        r_off  <= n_off;
        r_i    <= n_i;
        r_bad  <= n_bad;
        r_ovf  <= n_ovf;
        r_out  <= n_out;
        if (i_req.valid && i_req.ready) begin
            r_d <= i_req.data.start_day;
        end
    end

    always_comb begin
        n_state = r_state;
        n_m     = r_m;
        n_y     = r_y;
        n_r400  = r_r400;
        n_x     = r_x;
        n_doy   = r_doy;
        n_off   = r_off;
        n_i     = r_i;
        n_bad   = r_bad;
        n_ovf   = r_ovf;
        n_out   = r_out;
        n_ov    = r_ov && !o_rsp.ready;
        alu_in  = '{op: ALU_SUB, a: AW'(r_x), b: AW'(year_days(leap))};
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_m     = i_req.data.start_month;
                    n_y     = i_req.data.start_year;
                    n_r400  = i_req.data.start_year;
                    n_x     = XW'(i_req.data.days_to_add) & X_MASK;
                    n_bad   = 1'b0;
                    n_ovf   = 1'b0;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                alu_in = '{op: ALU_SUB, a: AW'(r_r400), b: AW'(CYCLE_LEN)};
                if (!alu_out.borrow) begin
                    n_r400 = alu_out.res[13:0];
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_doy = 9'(r_d);
                n_i   = 4'd1;
                if (date_ok) begin
                    n_state = S_DOY;
                end else begin
                    n_bad   = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DOY: begin
                alu_in = '{op: ALU_ADD, a: AW'(r_doy), b: AW'(month_days(r_i, leap))};
                if (r_i < r_m) begin
                    n_doy = alu_out.res[8:0];
                    n_i   = r_i + 4'd1;
                end else begin
                    n_state = S_REM;
                end
            end
            S_REM: begin
                alu_in  = '{op: ALU_SUB, a: AW'(year_days(leap)), b: AW'(r_doy)};
                n_off   = alu_out.res[8:0];
                n_state = S_FIRST;
            end
            S_FIRST: begin
                alu_in = '{op: ALU_SUB, a: AW'(r_x), b: AW'(r_off)};
                if (alu_out.borrow || alu_out.zero) begin
                    n_state = S_ADDX;
                end else begin
                    n_x     = alu_out.res[XW-1:0];
                    n_y     = r_y + 14'd1;
                    n_r400  = 14'(r400_inc);
                    n_state = S_YEAR;
                end
            end
            S_ADDX: begin
                alu_in  = '{op: ALU_ADD, a: AW'(r_doy), b: AW'(r_x)};
                n_off   = alu_out.res[8:0];
                n_i     = 4'd1;
                n_state = S_MONTH;
            end
            S_YEAR: begin
                n_i = 4'd1;
                if (r_y > YEAR_MAX) begin
                    n_ovf   = 1'b1;
                    n_state = S_DONE;
                end else if (!alu_out.borrow && !alu_out.zero) begin
                    n_x    = alu_out.res[XW-1:0];
                    n_y    = r_y + 14'd1;
                    n_r400 = 14'(r400_inc);
                end else begin
                    n_off   = r_x[8:0];
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                alu_in = '{op: ALU_SUB, a: AW'(r_off), b: AW'(month_days(r_i, leap))};
                if ((r_i < MONTH_DEC) && !alu_out.borrow && !alu_out.zero) begin
                    n_off = alu_out.res[8:0];
                    n_i   = r_i + 4'd1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov                = 1'b1;
                    n_out.date_invalid  = r_bad;
                    n_out.year_overflow = r_ovf;
                    if (r_bad) begin
                        n_out.new_day   = 5'd0;
                        n_out.new_month = 4'd0;
                        n_out.new_year  = 14'd0;
                    end else if (r_ovf) begin
                        n_out.new_day   = DAY_DEC31;
                        n_out.new_month = MONTH_DEC;
                        n_out.new_year  = YEAR_MAX;
                    end else begin
                        n_out.new_day   = r_off[4:0];
                        n_out.new_month = r_i;
                        n_out.new_year  = r_y;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.year_overflow) |->
        (r_out.new_year == YEAR_MAX && !r_out.date_invalid))
        else $error("overflowed result is not saturated");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.date_invalid) |->
        (r_out.new_day == 5'd0 && r_out.new_month == 4'd0 && r_out.new_year == 14'd0))
        else $error("invalid date gives non-zero result");

    a_month_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MONTH) |-> (r_i >= 4'd1 && r_i <= MONTH_DEC && r_y <= YEAR_MAX))
        else $error("month step out of range");

    a_cycle_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_YEAR || r_state == S_MONTH) |-> (r_r400 < CYCLE_LEN))
        else $error("year cycle position out of range");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_MOD) |=> (r_state != S_MOD))
        else $error("new request taken while busy");
endmodule

/* tb/tb.sv */
// Self-checking testbench for the Gregorian date adder with a scoreboard class.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdad_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 400;
    localparam int RANDOM_REQS = 528;
    localparam int PHASES      = 8;

    class date_scoreboard;
        t_rsp expected_q[$];
        int   errors;
        int   requests;
        int   invalid_seen;
        int   overflow_seen;
        int   year_end_seen;

        static function bit is_leap(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        static function int unsigned days_of_year(int unsigned y);
            return is_leap(y) ? 366 : 365;
        endfunction

        static function int unsigned month_length(int unsigned m, int unsigned y);
            int unsigned len;
            case (m)
                1, 3, 5, 7, 8, 10, 12: len = 31;
                4, 6, 9, 11:           len = 30;
                2:                     len = is_leap(y) ? 29 : 28;
                default:               len = 0;
            endcase
            return len;
        endfunction

        static function t_rsp later_date(t_req r);
            int unsigned d, m, y, x, doy, rest, yr, off, mo;
            t_rsp res;
            res = '0;
            d = r.start_day;
            m = r.start_month;
            y = r.start_year;
            x = r.days_to_add & ((32'd1 << ADD_WIDTH) - 1);
            if (y < 1500 || y > 9999 || m < 1 || m > 12 || d < 1 ||
                d > month_length(m, y)) begin
                res.date_invalid = 1'b1;
            end else begin
                doy = d;
                for (int unsigned i = 1; i < m; i++)
                    doy += month_length(i, y);
                rest = days_of_year(y) - doy;
                if (x <= rest) begin
                    yr  = y;
                    off = doy + x;
                end else begin
                    x  -= rest;
                    yr  = y + 1;
                    while (x > days_of_year(yr) && yr <= 9999) begin
                        x -= days_of_year(yr);
                        yr++;
                    end
                    off = x;
                end
                if (yr > 9999) begin
                    res.year_overflow = 1'b1;
                    res.new_day       = 5'd31;
                    res.new_month     = 4'd12;
                    res.new_year      = 14'd9999;
                end else begin
                    mo = 1;
                    while (mo < 12 && off > month_length(mo, yr)) begin
                        off -= month_length(mo, yr);
                        mo++;
                    end
                    res.new_day   = 5'(off);
                    res.new_month = 4'(mo);
                    res.new_year  = 14'(yr);
                end
            end
            return res;
        endfunction

        function void note_request(t_req r);
            t_rsp e;
            e = later_date(r);
            expected_q.push_back(e);
            requests++;
            if (e.date_invalid)
                invalid_seen++;
            if (e.year_overflow)
                overflow_seen++;
            if (!e.date_invalid && !e.year_overflow && e.new_day == 5'd31 &&
                e.new_month == 4'd12)
                year_end_seen++;
        endfunction

        function void check_result(t_rsp got);
            t_rsp e;
            if (expected_q.size() == 0) begin
                $error("Result arrived with no request outstanding: %p", got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.new_day !== e.new_day) begin
                $error("new_day: expected %0d, actual %0d", e.new_day, got.new_day);
                errors++;
            end
            if (got.new_month !== e.new_month) begin
                $error("new_month: expected %0d, actual %0d", e.new_month, got.new_month);
                errors++;
            end
            if (got.new_year !== e.new_year) begin
                $error("new_year: expected %0d, actual %0d", e.new_year, got.new_year);
                errors++;
            end
            if (got.date_invalid !== e.date_invalid) begin
                $error("date_invalid: expected %0b, actual %0b",
                       e.date_invalid, got.date_invalid);
                errors++;
            end
            if (got.year_overflow !== e.year_overflow) begin
                $error("year_overflow: expected %0b, actual %0b",
                       e.year_overflow, got.year_overflow);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   snk_stall_pct;
    int   cycles;

    date_scoreboard sb = new;

    cdad_req_if req_ch();
    cdad_rsp_if rsp_ch();

    calendar_date_add_days dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Run stopped after %0d cycles with %0d results outstanding.",
                 cycles, sb.pending());
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                sb.check_result(rsp_ch.data);
            rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic send_request(input t_req r);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do
            @(posedge i_clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(r);
    endtask

    task automatic send_date(input int unsigned d, input int unsigned m,
                             input int unsigned y, input int unsigned x);
        t_req r;
        r.start_day   = 5'(d);
        r.start_month = 4'(m);
        r.start_year  = 14'(y);
        r.days_to_add = DAYS_W'(x);
        send_request(r);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_req random_request();
        t_req        r;
        int unsigned sel, d, m, y, x, len, k;
        sel = $urandom_range(99);
        case ($urandom_range(3))
            0, 1:    y = $urandom_range(9999, 1500);
            2:       y = $urandom_range(9999, 9750);
            default: y = $urandom_range(1600, 1500);
        endcase
        m   = $urandom_range(12, 1);
        len = date_scoreboard::month_length(m, y);
        case ($urandom_range(3))
            0:       d = len;
            1:       d = 1;
            default: d = $urandom_range(len, 1);
        endcase
        case ($urandom_range(3))
            0:       x = $urandom_range(65535);
            1:       x = $urandom_range(400);
            2:       x = $urandom_range(65535, 60000);
            default: begin
                d = 31;
                m = 12;
                x = 0;
                k = $urandom_range(150);
                for (int unsigned i = 1; i <= k; i++)
                    x += date_scoreboard::days_of_year(y + i);
            end
        endcase
        if (sel >= 75 && sel < 90) begin
            case ($urandom_range(3))
                0:       d = (m == 2) ? $urandom_range(31, 30) : 0;
                1:       m = $urandom_range(1) ? 0 : $urandom_range(15, 13);
                2:       y = $urandom_range(1499);
                default: y = $urandom_range(16383, 10000);
            endcase
        end else if (sel >= 90) begin
            d = $urandom_range(31);
            m = $urandom_range(15);
            y = $urandom_range(16383);
            x = $urandom_range(65535);
        end
        r.start_day   = 5'(d);
        r.start_month = 4'(m);
        r.start_year  = 14'(y);
        r.days_to_add = DAYS_W'(x);
        return r;
    endfunction

    initial begin
        i_rst_n       <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.data   <= '0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_date(1, 1, 1500, 0);
        send_date(31, 12, 9999, 0);
        send_date(31, 12, 9999, 1);
        send_date(1, 1, 1500, 65535);
        send_date(1, 1, 9900, 65535);
        send_date(29, 2, 2000, 0);
        send_date(29, 2, 1900, 5);
        send_date(29, 2, 2004, 365);
        send_date(29, 2, 2001, 1);
        send_date(28, 2, 2024, 1);
        send_date(1, 1, 2023, 364);
        send_date(31, 12, 2023, 366);
        send_date(30, 12, 2100, 1);
        send_date(0, 6, 2020, 3);
        send_date(31, 4, 2020, 3);
        send_date(31, 15, 16383, 65535);
        send_date(15, 0, 2020, 10);
        send_date(15, 13, 2020, 10);
        send_date(15, 6, 1499, 10);
        send_date(15, 6, 10000, 10);
        send_date(31, 1, 1600, 59);
        send_date(1, 3, 9999, 305);
        send_date(1, 3, 9999, 306);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 68; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 68; end
                default: begin src_idle_pct = 36; snk_stall_pct = 36; end
            endcase
            for (int n = 0; n < RANDOM_REQS / PHASES; n++)
                send_request(random_request());
            drain();
        end

        snk_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Checked %0d date requests in %0d cycles under four handshake patterns.",
                 sb.requests, cycles);
        $display("Of these %0d had invalid start dates, %0d overflowed, %0d ended on 31/12.",
                 sb.invalid_seen, sb.overflow_seen, sb.year_end_seen);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
